/* rtl/framebuffer_scanout_compositor_unit_assert.svh */
`ifndef FRAMEBUFFER_SCANOUT_COMPOSITOR_UNIT_ASSERT_SVH
`define FRAMEBUFFER_SCANOUT_COMPOSITOR_UNIT_ASSERT_SVH
// implication checked on every edge outside reset
`define FSC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");
// next-cycle implication
`define FSC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");
`endif

/* rtl/fsc_pkg.sv */
package fsc_pkg;
    localparam int BANK_WORDS      = 65536;
    localparam int LINE_PIXELS     = 320;
    localparam int PALETTE_ENTRIES = 256;
    localparam int BANK_AW         = $clog2(BANK_WORDS);
    localparam int FRAME_AW        = BANK_AW + 1;
    localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
    localparam int POS_W           = 9;

    localparam logic [2:0] CMD_FRAME_WR = 3'd0;
    localparam logic [2:0] CMD_PAL_WR   = 3'd1;
    localparam logic [2:0] CMD_FILL     = 3'd2;
    localparam logic [2:0] CMD_SELECT   = 3'd3;
    localparam logic [2:0] CMD_LINE     = 3'd4;
    localparam logic [2:0] CMD_PIXEL    = 3'd5;

    localparam logic [1:0] MODE_BLANK  = 2'd0;
    localparam logic [1:0] MODE_PACKED = 2'd1;
    localparam logic [1:0] MODE_DIRECT = 2'd2;
    localparam logic [1:0] MODE_RUN    = 2'd3;

    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_PRIO  = 2'd1;
    localparam logic [1:0] REG_SHIFT = 2'd2;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [16:0] word_address;
        logic [15:0] word_data;
        logic [7:0]  palette_index;
        logic [7:0]  fill_length;
        logic        buffer_choice;
        logic        in_vblank;
        logic [7:0]  line_number;
        logic        backdrop_below;
    } req_t;

    typedef struct packed {
        logic [15:0] pixel_color;
        logic        pixel_shown;
    } res_t;
endpackage

/* rtl/fsc_if.sv */
interface fsc_req_if;
    import fsc_pkg::*;
    logic valid;
    logic ready;
    req_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface fsc_res_if;
    import fsc_pkg::*;
    logic valid;
    logic ready;
    res_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* rtl/framebuffer_scanout_compositor_unit.sv */
// framebuffer scanout compositor
// channels: req (sink) carries one command per request, res (source) gives
// one result per pixel command and none for the other commands
// configuration: apb-style port, mode at 0x0, priority at 0x4, dot shift at 0x8
// reset: frame memory (131072 words) and palette (256 words) are cleared by a
// sweep, during which no request is taken
// per command: frame, palette, select and unknown commands finish when taken;
// autofill writes fill_length+1 words; start line does one frame read
// pixel: packed mode, and run mode when a new run word is read, do a frame read
// then a palette read; the other modes do only the frame read
// a result is formed through ST_FRD, ST_PRD when there is a palette read, and
// ST_DONE; one request is in work at a time
// the result sits in an output register; while it waits the next request is
// taken and worked on, and only a new result waits for the register to drain
module framebuffer_scanout_compositor_unit
    import fsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    fsc_req_if.sink     req,
    fsc_res_if.source   res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    `include "framebuffer_scanout_compositor_unit_assert.svh"

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_FILL  = 7'b0000100,
        ST_FRD   = 7'b0001000,
        ST_PRD   = 7'b0010000,
        ST_DONE  = 7'b0100000,
        ST_HOLD  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    req_t cur_reg, cur_next;
    logic [FRAME_AW-1:0] clr_reg, clr_next;
    logic [1:0]  mode_reg;
    logic        prio_reg, shift_reg;
    logic        req_buf_reg, req_buf_next;
    logic        disp_reg, disp_next;
    logic [15:0] lfa_reg, lfa_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] run_rem_reg, run_rem_next;
    logic [15:0] run_col_reg, run_col_next;
    logic [15:0] fill_addr_reg, fill_addr_next;
    logic [7:0]  fill_cnt_reg, fill_cnt_next;
    logic        odd_reg, odd_next;
    logic        newrun_reg, newrun_next;
    logic        active_reg, active_next;
    logic        ovalid_reg, ovalid_next;
    res_t        out_reg, out_next;
    res_t        pend_reg, pend_next;
    logic [15:0] pix_col_reg;

    logic f_we, p_we;
    logic [FRAME_AW-1:0] f_waddr, f_raddr;
    logic [15:0] f_wdata, f_rdata, p_wdata, p_rdata;
    logic [PAL_AW-1:0] p_waddr, p_raddr;

    logic [POS_W-1:0] x;
    logic [15:0] color;
    logic        valid_pix;
    logic        through;
    logic        shown;
    res_t        pix;
    logic        acc;
    logic        cfg_wr;

    fsc_ram #(.WIDTH(16), .DEPTH(2 * BANK_WORDS)) u_frame (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .raddr(f_raddr), .rdata(f_rdata)
    );

    fsc_ram #(.WIDTH(16), .DEPTH(PALETTE_ENTRIES)) u_pal (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata)
    );

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_MODE:  prdata = {30'd0, mode_reg};
            REG_PRIO:  prdata = {31'd0, prio_reg};
            REG_SHIFT: prdata = {31'd0, shift_reg};
            default:   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_BLANK;
            prio_reg  <= 1'b0;
            shift_reg <= 1'b0;
        end
        else if (cfg_wr && paddr[1:0] == 2'd0)
        begin
            unique case (paddr[3:2])
                REG_MODE:  mode_reg  <= pwdata[1:0];
                REG_PRIO:  prio_reg  <= pwdata[0];
                REG_SHIFT: shift_reg <= pwdata[0];
                default:   ;
            endcase
        end
    end

    assign req.ready = (state_reg == ST_IDLE);
    assign acc       = req.valid && req.ready;
    assign res.valid = ovalid_reg;
    assign res.payload = out_reg;

    // pixel address and result
    assign x = pos_reg + {{(POS_W-1){1'b0}}, shift_reg};

    always_comb
    begin
        valid_pix = active_reg && (mode_reg != MODE_BLANK);
        unique case (mode_reg)
            MODE_PACKED: color = pix_col_reg;
            MODE_DIRECT: color = pix_col_reg;
            MODE_RUN:    color = run_col_reg;
            default:     color = 16'd0;
        endcase
        through = color[15];
        shown = valid_pix && ((prio_reg ? !through : through) || cur_reg.backdrop_below);
        pix.pixel_shown = shown;
        pix.pixel_color = shown ? (color | 16'h8000) : 16'd0;
    end

    always_comb
    begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        clr_next     = clr_reg;
        req_buf_next = req_buf_reg;
        disp_next    = disp_reg;
        lfa_next     = lfa_reg;
        pos_next     = pos_reg;
        run_rem_next = run_rem_reg;
        run_col_next = run_col_reg;
        fill_addr_next = fill_addr_reg;
        fill_cnt_next  = fill_cnt_reg;
        odd_next     = odd_reg;
        newrun_next  = newrun_reg;
        active_next  = active_reg;
        ovalid_next  = ovalid_reg;
        out_next     = out_reg;
        pend_next    = pend_reg;
        f_we    = 1'b0;
        f_waddr = '0;
        f_wdata = 16'd0;
        f_raddr = '0;
        p_we    = 1'b0;
        p_waddr = '0;
        p_wdata = 16'd0;
        p_raddr = '0;

        if (ovalid_reg && res.ready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                f_we    = 1'b1;
                f_waddr = clr_reg;
                p_we    = 1'b1;
                p_waddr = clr_reg[PAL_AW-1:0];
                clr_next = clr_reg + 1'b1;
                if (&clr_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (acc)
                begin
                    cur_next = req.payload;
                    unique case (req.payload.cmd)
                        CMD_FRAME_WR:
                        begin
                            f_we    = 1'b1;
                            f_waddr = req.payload.word_address[FRAME_AW-1:0];
                            f_wdata = req.payload.word_data;
                        end
                        CMD_PAL_WR:
                        begin
                            p_we    = 1'b1;
                            p_waddr = req.payload.palette_index[PAL_AW-1:0];
                            p_wdata = req.payload.word_data;
                        end
                        CMD_FILL:
                        begin
                            fill_addr_next = req.payload.word_address[15:0];
                            fill_cnt_next  = req.payload.fill_length;
                            state_next     = ST_FILL;
                        end
                        CMD_SELECT:
                        begin
                            req_buf_next = req.payload.buffer_choice;
                            if (req.payload.in_vblank || mode_reg == MODE_BLANK)
                            begin
                                disp_next = req.payload.buffer_choice;
                            end
                        end
                        CMD_LINE:
                        begin
                            f_raddr    = {~disp_reg,
                                {(BANK_AW-8){1'b0}}, req.payload.line_number};
                            state_next = ST_FRD;
                        end
                        CMD_PIXEL:
                        begin
                            active_next = (pos_reg < POS_W'(LINE_PIXELS));
                            newrun_next = 1'b0;
                            odd_next    = x[0];
                            if (pos_reg < POS_W'(LINE_PIXELS))
                            begin
                                pos_next = pos_reg + 1'b1;
                            end
                            unique case (mode_reg)
                                MODE_PACKED:
                                    f_raddr = {~disp_reg,
                                        BANK_AW'(lfa_reg + 16'(x >> 1))};
                                MODE_DIRECT:
                                    f_raddr = {~disp_reg,
                                        BANK_AW'(lfa_reg + 16'(pos_reg))};
                                MODE_RUN:
                                begin
                                    f_raddr = {~disp_reg, BANK_AW'(lfa_reg)};
                                    if (pos_reg < POS_W'(LINE_PIXELS))
                                    begin
                                        if (run_rem_reg == '0)
                                        begin
                                            newrun_next = 1'b1;
                                            lfa_next    = lfa_reg + 16'd1;
                                        end
                                        else
                                        begin
                                            run_rem_next = run_rem_reg - 1'b1;
                                        end
                                    end
                                end
                                default: f_raddr = '0;
                            endcase
                            state_next = ST_FRD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_FILL:
            begin
                f_we    = 1'b1;
                f_waddr = {disp_reg, BANK_AW'(fill_addr_reg)};
                f_wdata = cur_reg.word_data;
                fill_addr_next = {fill_addr_reg[15:8], fill_addr_reg[7:0] + 8'd1};
                fill_cnt_next  = fill_cnt_reg - 8'd1;
                if (fill_cnt_reg == 8'd0)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FRD:
            begin
                if (cur_reg.cmd == CMD_LINE)
                begin
                    lfa_next     = f_rdata;
                    pos_next     = '0;
                    run_rem_next = '0;
                    run_col_next = 16'd0;
                    state_next   = ST_IDLE;
                end
                else if (mode_reg == MODE_PACKED)
                begin
                    p_raddr    = odd_reg ? f_rdata[7:0] : f_rdata[15:8];
                    state_next = ST_PRD;
                end
                else if (mode_reg == MODE_RUN && newrun_reg)
                begin
                    p_raddr      = f_rdata[7:0];
                    run_rem_next = {1'b0, f_rdata[15:8]};
                    state_next   = ST_PRD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_PRD:
            begin
                if (newrun_reg)
                begin
                    run_col_next = p_rdata;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                f_raddr = '0;
                if (!ovalid_next)
                begin
                    ovalid_next = 1'b1;
                    out_next    = pix;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    pend_next  = pix;
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!ovalid_next)
                begin
                    ovalid_next = 1'b1;
                    out_next    = pend_reg;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // read data holds only for the cycle after its read; keep the pixel word
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FRD)
        begin
            pix_col_reg <= f_rdata;
        end
        else if (state_reg == ST_PRD)
        begin
            pix_col_reg <= p_rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            req_buf_reg <= 1'b0;
            disp_reg    <= 1'b0;
            lfa_reg     <= 16'd0;
            pos_reg     <= '0;
            run_rem_reg <= '0;
            run_col_reg <= 16'd0;
            fill_cnt_reg <= 8'd0;
            active_reg  <= 1'b0;
            newrun_reg  <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            req_buf_reg <= req_buf_next;
            disp_reg    <= disp_next;
            lfa_reg     <= lfa_next;
            pos_reg     <= pos_next;
            run_rem_reg <= run_rem_next;
            run_col_reg <= run_col_next;
            fill_cnt_reg <= fill_cnt_next;
            active_reg  <= active_next;
            newrun_reg  <= newrun_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        fill_addr_reg <= fill_addr_next;
        odd_reg       <= odd_next;
        pend_reg      <= pend_next;
        out_reg       <= out_next;
    end

    `FSC_ASSERT_IMP(a_ready_idle, req.ready, state_reg == ST_IDLE)
    `FSC_ASSERT_IMP(a_no_shown_zero, res.valid && !res.payload.pixel_shown,
        res.payload.pixel_color == 16'd0)
    `FSC_ASSERT_IMP(a_shown_bit15, res.valid && res.payload.pixel_shown,
        res.payload.pixel_color[15])
    `FSC_ASSERT_IMP(a_pos_bound, 1'b1, pos_reg <= POS_W'(LINE_PIXELS))
    `FSC_ASSERT_NXT(a_fill_leaves, state_reg == ST_FILL && fill_cnt_reg == 8'd0,
        state_reg == ST_IDLE)
endmodule

/* rtl/fsc_ram.sv */
module fsc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
